/* rtl/gnl_pkg.sv */
// Shared constants, types and helpers for the grid neighbour lister.
package gnl_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CHAR_W = 8;
    localparam int DIM_W  = 7;
    localparam int ID_W   = 12;
    localparam int IDX_W  = 4;
    localparam int NB_N   = 8;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NB_N + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_ROWS    = 2'd0;
    localparam logic [1:0] REG_COLS    = 2'd1;
    localparam logic [1:0] REG_BLOCKED = 2'd2;

    localparam logic [DIM_W-1:0]  ROWS_RST    = DIM_W'(64);
    localparam logic [DIM_W-1:0]  COLS_RST    = DIM_W'(64);
    localparam logic [CHAR_W-1:0] BLOCKED_RST = CHAR_W'(120);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    // Neighbour slots 1..8: L, R, T, TL, TR, B, BL, BR (slot 0 is the cell)
    function automatic logic nb_up(input logic [IDX_W-1:0] k);
        return (k == 4'd3) || (k == 4'd4) || (k == 4'd5);
    endfunction

    function automatic logic nb_down(input logic [IDX_W-1:0] k);
        return (k == 4'd6) || (k == 4'd7) || (k == 4'd8);
    endfunction

    function automatic logic nb_left(input logic [IDX_W-1:0] k);
        return (k == 4'd1) || (k == 4'd4) || (k == 4'd7);
    endfunction

    function automatic logic nb_right(input logic [IDX_W-1:0] k);
        return (k == 4'd2) || (k == 4'd5) || (k == 4'd8);
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > lim) begin
            r = DIM_W'(lim);
        end
        return r;
    endfunction

endpackage

/* rtl/grid_eight_neighbour_lister.sv */
// Grid neighbour lister top level: cell store, query sequencer, result register.
// A write is stored at accept; an out-of-range item yields its result beat at accept.
// A query is accepted, then the cell and its 8 neighbours are read in turn
// through the single RAM read port, then the result beats (1 to 8) are emitted.
// No new item is accepted while a query is in progress or a stalled output holds the result register.
// Synchronous active-low reset clears control state and config registers; cell RAM and data are not cleared.
module grid_eight_neighbour_lister (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [gnl_pkg::ROW_W-1:0]   i_cell_row,
    input  logic [gnl_pkg::COL_W-1:0]   i_cell_col,
    input  logic [gnl_pkg::CHAR_W-1:0]  i_cell_char,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gnl_pkg::ID_W-1:0]    o_node_id,
    output logic [gnl_pkg::ID_W-1:0]    o_neighbour_id,
    output logic                        o_neighbour_valid,
    output logic                        o_bad_position,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);

    gnl_pkg::t_state r_state, n_state;

    logic [gnl_pkg::DIM_W-1:0]  r_rows, r_cols;
    logic [gnl_pkg::CHAR_W-1:0] r_blocked;

    logic [gnl_pkg::ADDR_W-1:0] r_addr;
    logic [gnl_pkg::ID_W-1:0]   r_node;
    logic [gnl_pkg::NB_N-1:0]   r_inr;
    logic [gnl_pkg::NB_N-1:0]   r_mask;
    logic                       r_ctr_ok;
    logic [gnl_pkg::IDX_W-1:0]  r_idx;

    logic                       r_out_valid;
    logic [gnl_pkg::ID_W-1:0]   r_out_node, r_out_nb;
    logic                       r_out_nbv, r_out_bad, r_out_last;

    logic                       w_in_accept, w_slot_free, w_in_range;
    logic [gnl_pkg::ADDR_W-1:0] w_addr, w_raddr;
    logic [gnl_pkg::ID_W-1:0]   w_node;
    logic [gnl_pkg::NB_N-1:0]   w_inr;
    logic [gnl_pkg::CHAR_W-1:0] w_rdata;
    logic                       w_mem_we;
    logic [gnl_pkg::IDX_W-1:0]  w_rk;
    logic [2:0]                 w_rk_bit, w_iss_bit;
    logic [gnl_pkg::NB_N-1:0]   w_eff;
    logic [gnl_pkg::NB_N-1:0]   w_pick;
    logic [gnl_pkg::IDX_W-1:0]  w_pick_k;
    logic [gnl_pkg::ID_W-1:0]   w_nb_id;
    logic                       w_out_load, w_out_nbv, w_out_bad, w_out_last;
    logic [gnl_pkg::ID_W-1:0]   w_out_node, w_out_nb;
    logic [gnl_pkg::ID_W-1:0]   w_cols_id;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Position decode at accept
    assign w_in_range = ({1'b0, i_cell_row} < r_rows) && ({1'b0, i_cell_col} < r_cols);
    assign w_addr = gnl_pkg::ADDR_W'(i_cell_row) * gnl_pkg::ADDR_W'(gnl_pkg::MAX_COLS)
                  + gnl_pkg::ADDR_W'(i_cell_col);
    assign w_node = gnl_pkg::ID_W'(i_cell_row) * gnl_pkg::ID_W'(r_cols)
                  + gnl_pkg::ID_W'(i_cell_col);

    always_comb begin
        logic up_ok, dn_ok, lf_ok, rt_ok;
        up_ok = (i_cell_row != '0);
        dn_ok = ({1'b0, i_cell_row} + gnl_pkg::DIM_W'(1)) < r_rows;
        lf_ok = (i_cell_col != '0);
        rt_ok = ({1'b0, i_cell_col} + gnl_pkg::DIM_W'(1)) < r_cols;
        w_inr = {dn_ok && rt_ok, dn_ok && lf_ok, dn_ok,
                 up_ok && rt_ok, up_ok && lf_ok, up_ok, rt_ok, lf_ok};
    end

    assign w_mem_we = w_in_accept && w_in_range && (i_opcode == gnl_pkg::OP_WRITE);

    // Read address for slot r_idx
    assign w_iss_bit = 3'(r_idx - gnl_pkg::IDX_W'(1));
    always_comb begin
        logic [gnl_pkg::ADDR_W-1:0] a;
        a = r_addr;
        if (gnl_pkg::nb_up(r_idx)) begin
            a = a - gnl_pkg::ADDR_W'(gnl_pkg::MAX_COLS);
        end else if (gnl_pkg::nb_down(r_idx)) begin
            a = a + gnl_pkg::ADDR_W'(gnl_pkg::MAX_COLS);
        end
        if (gnl_pkg::nb_left(r_idx)) begin
            a = a - gnl_pkg::ADDR_W'(1);
        end else if (gnl_pkg::nb_right(r_idx)) begin
            a = a + gnl_pkg::ADDR_W'(1);
        end
        w_raddr = r_addr;
        if (r_idx != '0 && r_idx < gnl_pkg::IDX_LAST && r_inr[w_iss_bit]) begin
            w_raddr = a;
        end
    end

    gnl_grid_ram #(
        .DATA_W (gnl_pkg::CHAR_W),
        .DEPTH  (gnl_pkg::DEPTH),
        .ADDR_W (gnl_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_addr),
        .i_wdata (i_cell_char),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Slot whose data returns this cycle
    assign w_rk     = r_idx - gnl_pkg::IDX_W'(1);
    assign w_rk_bit = 3'(w_rk - gnl_pkg::IDX_W'(1));

    // Emit selection: lowest pending neighbour
    assign w_eff = r_mask & {gnl_pkg::NB_N{r_ctr_ok}};
    always_comb begin
        w_pick   = '0;
        w_pick_k = '0;
        for (int j = gnl_pkg::NB_N - 1; j >= 0; j--) begin
            if (w_eff[j]) begin
                w_pick   = gnl_pkg::NB_N'(1) << j;
                w_pick_k = gnl_pkg::IDX_W'(j + 1);
            end
        end
    end

    assign w_cols_id = gnl_pkg::ID_W'(r_cols);
    always_comb begin
        logic [gnl_pkg::ID_W-1:0] v;
        v = r_node;
        if (gnl_pkg::nb_up(w_pick_k)) begin
            v = v - w_cols_id;
        end else if (gnl_pkg::nb_down(w_pick_k)) begin
            v = v + w_cols_id;
        end
        if (gnl_pkg::nb_left(w_pick_k)) begin
            v = v - gnl_pkg::ID_W'(1);
        end else if (gnl_pkg::nb_right(w_pick_k)) begin
            v = v + gnl_pkg::ID_W'(1);
        end
        w_nb_id = v;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gnl_pkg::S_IDLE: begin
                if (w_in_accept && w_in_range && (i_opcode == gnl_pkg::OP_QUERY)) begin
                    n_state = gnl_pkg::S_READ;
                end
            end
            gnl_pkg::S_READ: begin
                if (r_idx == gnl_pkg::IDX_LAST) begin
                    n_state = gnl_pkg::S_EMIT;
                end
            end
            gnl_pkg::S_EMIT: begin
                if (w_slot_free && ((w_eff & ~w_pick) == '0)) begin
                    n_state = gnl_pkg::S_IDLE;
                end
            end
            default: n_state = gnl_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        w_out_load = 1'b0;
        w_out_node = '0;
        w_out_nb   = '0;
        w_out_nbv  = 1'b0;
        w_out_bad  = 1'b0;
        w_out_last = 1'b1;
        unique case (r_state)
            gnl_pkg::S_IDLE: begin
                o_in_stall = !w_slot_free;
                w_out_load = w_in_accept && !w_in_range;
                w_out_bad  = 1'b1;
            end
            gnl_pkg::S_READ: begin
                o_in_stall = 1'b1;
            end
            gnl_pkg::S_EMIT: begin
                w_out_load = w_slot_free;
                w_out_node = r_node;
                if (w_eff != '0) begin
                    w_out_nb   = w_nb_id;
                    w_out_nbv  = 1'b1;
                    w_out_last = (w_eff & ~w_pick) == '0;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gnl_pkg::S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_rows      <= gnl_pkg::ROWS_RST;
            r_cols      <= gnl_pkg::COLS_RST;
            r_blocked   <= gnl_pkg::BLOCKED_RST;
        end else begin
            r_state <= n_state;
            if (r_state == gnl_pkg::S_READ) begin
                r_idx <= r_idx + gnl_pkg::IDX_W'(1);
            end else begin
                r_idx <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gnl_pkg::REG_ROWS:
                        r_rows <= gnl_pkg::sat_dim(i_cfg_data[6:0], gnl_pkg::MAX_ROWS);
                    gnl_pkg::REG_COLS:
                        r_cols <= gnl_pkg::sat_dim(i_cfg_data[6:0], gnl_pkg::MAX_COLS);
                    gnl_pkg::REG_BLOCKED:
                        r_blocked <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Query payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_addr <= w_addr;
            r_node <= w_node;
            r_inr  <= w_inr;
            r_mask <= '0;
        end else if (r_state == gnl_pkg::S_READ && r_idx != '0) begin
            if (w_rk == '0) begin
                r_ctr_ok <= (w_rdata != r_blocked);
            end else begin
                r_mask[w_rk_bit] <= r_inr[w_rk_bit] && (w_rdata != r_blocked);
            end
        end else if (r_state == gnl_pkg::S_EMIT && w_slot_free) begin
            r_mask <= r_mask & ~w_pick;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_node <= w_out_node;
            r_out_nb   <= w_out_nb;
            r_out_nbv  <= w_out_nbv;
            r_out_bad  <= w_out_bad;
            r_out_last <= w_out_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_node_id         = r_out_node;
    assign o_neighbour_id    = r_out_nb;
    assign o_neighbour_valid = r_out_nbv;
    assign o_bad_position    = r_out_bad;
    assign o_last            = r_out_last;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gnl_pkg::S_IDLE) |-> o_in_stall)
        else $error("input taken while a query is in progress");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_position) |-> (o_last && !o_neighbour_valid))
        else $error("bad position beat not a lone final beat");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_neighbour_valid) |-> o_last)
        else $error("beat without neighbour is not final");

    a_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gnl_pkg::S_READ) |-> (r_idx <= gnl_pkg::IDX_LAST))
        else $error("read sweep overran");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gnl_pkg::S_EMIT && w_out_load && w_out_last)
            |=> (r_state == gnl_pkg::S_IDLE))
        else $error("sequencer did not return to idle after final beat");

endmodule

/* rtl/gnl_grid_ram.sv */
// Simple dual-port RAM holding the grid cells, registered read.
module gnl_grid_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/gnl_result_checker.sv */
// Result checker for the grid neighbour lister: tracks cells and registers, predicts beats.
module gnl_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_opcode,
    input  logic [gnl_pkg::ROW_W-1:0]  i_cell_row,
    input  logic [gnl_pkg::COL_W-1:0]  i_cell_col,
    input  logic [gnl_pkg::CHAR_W-1:0] i_cell_char,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [gnl_pkg::ID_W-1:0]   i_node_id,
    input  logic [gnl_pkg::ID_W-1:0]   i_neighbour_id,
    input  logic                       i_neighbour_valid,
    input  logic                       i_bad_position,
    input  logic                       i_last,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [gnl_pkg::ID_W-1:0] node_id;
        logic [gnl_pkg::ID_W-1:0] neighbour_id;
        logic                     neighbour_valid;
        logic                     bad_position;
        logic                     last;
    } t_beat;

    t_beat                      expected_beats [$];
    logic [gnl_pkg::CHAR_W-1:0] cell_chars [gnl_pkg::DEPTH];
    logic [gnl_pkg::DIM_W-1:0]  rows_reg;
    logic [gnl_pkg::DIM_W-1:0]  cols_reg;
    logic [gnl_pkg::CHAR_W-1:0] blocked_reg;
    int                         fails = 0;

    // L, R, T, TL, TR, B, BL, BR
    function automatic int row_step(input int k);
        int s;
        s = 0;
        if (k >= 2 && k <= 4) begin
            s = -1;
        end else if (k >= 5) begin
            s = 1;
        end
        return s;
    endfunction

    function automatic int col_step(input int k);
        int s;
        s = 0;
        if (k == 0 || k == 3 || k == 6) begin
            s = -1;
        end else if (k == 1 || k == 4 || k == 7) begin
            s = 1;
        end
        return s;
    endfunction

    function automatic int dim_in_use(input logic [gnl_pkg::DIM_W-1:0] v, input int lim);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    task automatic add_beat(input t_beat b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic list_neighbours(input logic op, input logic [gnl_pkg::ROW_W-1:0] row,
                                   input logic [gnl_pkg::COL_W-1:0] col,
                                   input logic [gnl_pkg::CHAR_W-1:0] ch);
        int                       rows;
        int                       cols;
        int                       nr;
        int                       nc;
        bit                       held;
        t_beat                    prev;
        logic [gnl_pkg::ID_W-1:0] node;
        rows = dim_in_use(rows_reg, gnl_pkg::MAX_ROWS);
        cols = dim_in_use(cols_reg, gnl_pkg::MAX_COLS);
        held = 1'b0;
        prev = '0;
        if (int'(row) >= rows || int'(col) >= cols) begin
            add_beat('{node_id: '0, neighbour_id: '0, neighbour_valid: 1'b0,
                       bad_position: 1'b1, last: 1'b1});
        end else if (op == gnl_pkg::OP_WRITE) begin
            cell_chars[int'(row) * gnl_pkg::MAX_COLS + int'(col)] = ch;
        end else begin
            node = gnl_pkg::ID_W'(int'(row) * cols + int'(col));
            if (cell_chars[int'(row) * gnl_pkg::MAX_COLS + int'(col)] != blocked_reg) begin
                for (int k = 0; k < gnl_pkg::NB_N; k++) begin
                    nr = int'(row) + row_step(k);
                    nc = int'(col) + col_step(k);
                    if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
                        cell_chars[nr * gnl_pkg::MAX_COLS + nc] != blocked_reg) begin
                        if (held) begin
                            add_beat(prev);
                        end
                        prev = '{node_id: node,
                                 neighbour_id: gnl_pkg::ID_W'(nr * cols + nc),
                                 neighbour_valid: 1'b1, bad_position: 1'b0, last: 1'b0};
                        held = 1'b1;
                    end
                end
            end
            if (held) begin
                prev.last = 1'b1;
                add_beat(prev);
            end else begin
                add_beat('{node_id: node, neighbour_id: '0,
                           neighbour_valid: 1'b0, bad_position: 1'b0,
                           last: 1'b1});
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            rows_reg    = gnl_pkg::ROWS_RST;
            cols_reg    = gnl_pkg::COLS_RST;
            blocked_reg = gnl_pkg::BLOCKED_RST;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    gnl_pkg::REG_ROWS: begin
                        rows_reg = i_cfg_data[gnl_pkg::DIM_W-1:0];
                    end
                    gnl_pkg::REG_COLS: begin
                        cols_reg = i_cfg_data[gnl_pkg::DIM_W-1:0];
                    end
                    gnl_pkg::REG_BLOCKED: begin
                        blocked_reg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                list_neighbours(i_opcode, i_cell_row, i_cell_col, i_cell_char);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{node_id: i_node_id, neighbour_id: i_neighbour_id,
                        neighbour_valid: i_neighbour_valid, bad_position: i_bad_position,
                        last: i_last};
                if (expected_beats.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected beat: node %0d nb %0d nbv %0b bad %0b last %0b",
                             $time, got.node_id, got.neighbour_id, got.neighbour_valid,
                             got.bad_position, got.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.node_id !== want.node_id ||
                        got.neighbour_id !== want.neighbour_id ||
                        got.neighbour_valid !== want.neighbour_valid ||
                        got.bad_position !== want.bad_position ||
                        got.last !== want.last) begin
                        fails++;
                        $display("%0t: mismatch: expected node %0d nb %0d nbv %0b bad %0b last %0b",
                                 $time, want.node_id, want.neighbour_id,
                                 want.neighbour_valid, want.bad_position, want.last);
                        $display("%0t:           actual   node %0d nb %0d nbv %0b bad %0b last %0b",
                                 $time, got.node_id, got.neighbour_id, got.neighbour_valid,
                                 got.bad_position, got.last);
                    end
                end
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/grid_eight_neighbour_lister_tb.sv */
// Stimulus, stall patterns and verdict for the grid neighbour lister.
module grid_eight_neighbour_lister_tb;

    localparam logic [1:0] REG_SPARE     = 2'd3;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         PHASE_ITEMS   = 50;
    localparam int         LIMIT_CYCLES  = 1000000;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic                       in_opcode   = gnl_pkg::OP_WRITE;
    logic [gnl_pkg::ROW_W-1:0]  in_row      = '0;
    logic [gnl_pkg::COL_W-1:0]  in_col      = '0;
    logic [gnl_pkg::CHAR_W-1:0] in_char     = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic [gnl_pkg::ID_W-1:0]   node_id;
    logic [gnl_pkg::ID_W-1:0]   neighbour_id;
    logic                       neighbour_valid;
    logic                       bad_position;
    logic                       last;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index   = gnl_pkg::REG_ROWS;
    logic [7:0]                 cfg_data    = '0;
    int                         mismatches;
    int                         beats_left;

    bit                         cell_written [gnl_pkg::DEPTH];
    int                         grid_h    = 64;
    int                         grid_w    = 64;
    logic [gnl_pkg::CHAR_W-1:0] blk_char  = gnl_pkg::BLOCKED_RST;
    int                         items_sent = 0;
    bit                         tx_quiet  = 1'b0;
    bit                         rx_quiet  = 1'b0;
    bit                         hold_req  = 1'b0;

    grid_eight_neighbour_lister i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (in_opcode),
        .i_cell_row        (in_row),
        .i_cell_col        (in_col),
        .i_cell_char       (in_char),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_node_id         (node_id),
        .o_neighbour_id    (neighbour_id),
        .o_neighbour_valid (neighbour_valid),
        .o_bad_position    (bad_position),
        .o_last            (last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    gnl_result_checker u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_opcode          (in_opcode),
        .i_cell_row        (in_row),
        .i_cell_col        (in_col),
        .i_cell_char       (in_char),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_node_id         (node_id),
        .i_neighbour_id    (neighbour_id),
        .i_neighbour_valid (neighbour_valid),
        .i_bad_position    (bad_position),
        .i_last            (last),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (mismatches),
        .o_pending         (beats_left)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int dim_of(input logic [7:0] v, input int lim);
        int m;
        m = int'(v & 8'h7f);
        if (m == 0) begin
            return 1;
        end
        return (m > lim) ? lim : m;
    endfunction

    function automatic bit in_grid(input int r, input int c);
        return r >= 0 && c >= 0 && r < grid_h && c < grid_w;
    endfunction

    // a query may only touch cells that were written
    function automatic bit query_ready(input int r, input int c);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (in_grid(r + dr, c + dc) &&
                    !cell_written[(r + dr) * gnl_pkg::MAX_COLS + c + dc]) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [gnl_pkg::CHAR_W-1:0] pick_char();
        return ($urandom_range(0, 2) == 0) ? blk_char
                                           : gnl_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input logic op, input int row, input int col,
                             input logic [gnl_pkg::CHAR_W-1:0] ch);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_row    <= gnl_pkg::ROW_W'(row);
        in_col    <= gnl_pkg::COL_W'(col);
        in_char   <= ch;
        do @(posedge clk); while (in_stall);
        if (op == gnl_pkg::OP_WRITE && in_grid(row, col)) begin
            cell_written[row * gnl_pkg::MAX_COLS + col] = 1'b1;
        end
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (beats_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] rows_v, input logic [7:0] cols_v,
                             input logic [7:0] blk_v, input bit spare);
        drain();
        set_reg(gnl_pkg::REG_ROWS, rows_v);
        set_reg(gnl_pkg::REG_COLS, cols_v);
        set_reg(gnl_pkg::REG_BLOCKED, blk_v);
        if (spare) begin
            set_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        end
        grid_h   = dim_of(rows_v, gnl_pkg::MAX_ROWS);
        grid_w   = dim_of(cols_v, gnl_pkg::MAX_COLS);
        blk_char = blk_v;
    endtask

    // fill a 3x3 patch, then query cells inside it
    task automatic patch_and_query();
        int r;
        int c;
        int qr;
        int qc;
        r = $urandom_range(0, grid_h - 1);
        c = $urandom_range(0, grid_w - 1);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (in_grid(r + dr, c + dc) &&
                    (!cell_written[(r + dr) * gnl_pkg::MAX_COLS + c + dc] ||
                     $urandom_range(0, 3) == 0)) begin
                    send_beat(gnl_pkg::OP_WRITE, r + dr, c + dc, pick_char());
                end
            end
        end
        repeat ($urandom_range(1, 3)) begin
            qr = r + int'($urandom_range(0, 2)) - 1;
            qc = c + int'($urandom_range(0, 2)) - 1;
            if (!in_grid(qr, qc) || !query_ready(qr, qc)) begin
                qr = r;
                qc = c;
            end
            send_beat(gnl_pkg::OP_QUERY, qr, qc, gnl_pkg::CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_step();
        int pick;
        int r;
        int c;
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, grid_h - 1);
        c = $urandom_range(0, grid_w - 1);
        if (pick < 55) begin
            patch_and_query();
        end else if (pick < 75) begin
            if (query_ready(r, c)) begin
                send_beat(gnl_pkg::OP_QUERY, r, c, gnl_pkg::CHAR_W'($urandom_range(0, 255)));
            end else begin
                send_beat(gnl_pkg::OP_WRITE, r, c, pick_char());
            end
        end else if (pick < 88) begin
            send_beat(gnl_pkg::OP_WRITE, r, c, pick_char());
        end else if (grid_h < gnl_pkg::MAX_ROWS) begin
            send_beat(logic'($urandom_range(0, 1)), $urandom_range(grid_h, 63),
                      $urandom_range(0, 63), gnl_pkg::CHAR_W'($urandom_range(0, 255)));
        end else if (grid_w < gnl_pkg::MAX_COLS) begin
            send_beat(logic'($urandom_range(0, 1)), $urandom_range(0, 63),
                      $urandom_range(grid_w, 63), gnl_pkg::CHAR_W'($urandom_range(0, 255)));
        end else begin
            send_beat(gnl_pkg::OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                      pick_char());
        end
    endtask

    initial begin : sink
        int wait_n;
        wait (rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                wait_n   = HOLD_CYCLES;
            end else begin
                wait_n = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : source
        int goal;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cell with a blocked diagonal, then isolated
        send_beat(gnl_pkg::OP_WRITE, 0, 0, 8'd97);
        send_beat(gnl_pkg::OP_WRITE, 0, 1, 8'd0);
        send_beat(gnl_pkg::OP_WRITE, 1, 0, 8'd255);
        send_beat(gnl_pkg::OP_WRITE, 1, 1, gnl_pkg::BLOCKED_RST);
        send_beat(gnl_pkg::OP_QUERY, 0, 0, 8'd255);
        send_beat(gnl_pkg::OP_WRITE, 0, 1, gnl_pkg::BLOCKED_RST);
        send_beat(gnl_pkg::OP_WRITE, 1, 0, gnl_pkg::BLOCKED_RST);
        send_beat(gnl_pkg::OP_QUERY, 0, 0, 8'd0);
        // far corner: blocked cell, then crossable
        send_beat(gnl_pkg::OP_WRITE, 63, 62, 8'd97);
        send_beat(gnl_pkg::OP_WRITE, 62, 63, 8'd255);
        send_beat(gnl_pkg::OP_WRITE, 62, 62, 8'd0);
        send_beat(gnl_pkg::OP_WRITE, 63, 63, gnl_pkg::BLOCKED_RST);
        send_beat(gnl_pkg::OP_QUERY, 63, 63, 8'd170);
        send_beat(gnl_pkg::OP_WRITE, 63, 63, 8'd255);
        send_beat(gnl_pkg::OP_QUERY, 63, 63, 8'd85);
        // zero rows saturate to a 1x1 grid; out-of-range items
        configure(8'd0, 8'd1, 8'd0, 1'b0);
        send_beat(gnl_pkg::OP_QUERY, 0, 0, 8'd0);
        send_beat(gnl_pkg::OP_WRITE, 0, 5, 8'd33);
        send_beat(gnl_pkg::OP_QUERY, 7, 0, 8'd0);
        send_beat(gnl_pkg::OP_WRITE, 63, 63, 8'd0);

        for (int ph = 0; ph < 8; ph++) begin
            unique case (ph)
                0: configure(8'd64, 8'd64, gnl_pkg::BLOCKED_RST, 1'b0);
                1: configure(8'd4, 8'd4, 8'd0, 1'b0);
                2: configure(8'd5, 8'd7, 8'd255, 1'b1);
                3: configure(8'd1, 8'd64, 8'($urandom_range(0, 255)), 1'b0);
                4: configure(8'd64, 8'd1, 8'($urandom_range(0, 255)), 1'b0);
                5: configure(8'd127, 8'd200, 8'($urandom_range(0, 255)), 1'b1);
                6: configure(8'd2, 8'd2, 8'($urandom_range(0, 255)), 1'b0);
                default: configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                                   8'($urandom_range(0, 255)), 1'b0);
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                // output held off while the input keeps pushing
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                hold_req = 1'b1;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                random_step();
            end
        end
        drain();

        if (mismatches == 0 && beats_left == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
